>>> src/lru_tag_cache_core_defines.svh
`ifndef LRU_TAG_CACHE_CORE_DEFINES_SVH
`define LRU_TAG_CACHE_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define LTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define LTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lrutc_pkg.sv
package lrutc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 32;

    localparam int OPCODE_W = 2;
    localparam int KEY_W    = 64;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PROBE  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic              cmp;        // capture tag match
        logic              upd;        // apply state update
        logic              clr;
        logic              touch;      // hit: make matching entry most recent
        logic              ins_new;    // insert miss: fill victim, age the rest
        logic              wr_handle;  // hit on insert: overwrite handle
        logic              full;
        logic [RANK_W-1:0] hit_rank;
    } t_cell_cmd;

endpackage

>>> src/lrutc_cell.sv
module lrutc_cell
    import lrutc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_cmd             i_cmd,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_free_seen,
    output logic                  o_free_seen,
    output logic                  o_match,
    output logic [VALUE_BITS-1:0] o_hit_handle,
    output logic [RANK_W-1:0]     o_hit_rank
);

    logic                  r_valid;
    logic [RANK_W-1:0]     r_rank;
    logic [KEY_BITS-1:0]   r_tag;
    logic [VALUE_BITS-1:0] r_handle;
    logic                  r_match;

    logic n_valid;
    logic [RANK_W-1:0] n_rank;
    logic w_free;
    logic w_lru;
    logic w_victim;

    assign w_free      = !r_valid;
    assign o_free_seen = i_free_seen | w_free;
    assign w_lru       = r_valid && (r_rank == RANK_W'(ENTRIES - 1));
    assign w_victim    = i_cmd.full ? w_lru : (w_free && !i_free_seen);

    assign o_match      = r_match;
    assign o_hit_handle = r_match ? r_handle : '0;
    assign o_hit_rank   = r_match ? r_rank : '0;

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        if (i_cmd.upd) begin
            if (i_cmd.clr) begin
                n_valid = 1'b0;
                n_rank  = '0;
            end else if (i_cmd.touch) begin
                if (r_match) begin
                    n_rank = '0;
                end else if (r_valid && (r_rank < i_cmd.hit_rank)) begin
                    n_rank = r_rank + 1'b1;
                end
            end else if (i_cmd.ins_new) begin
                if (w_victim) begin
                    n_valid = 1'b1;
                    n_rank  = '0;
                end else if (r_valid) begin
                    n_rank = r_rank + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_match <= r_valid && (r_tag == i_key);
        end
        if (i_cmd.upd && !i_cmd.clr) begin
            if (i_cmd.touch && r_match && i_cmd.wr_handle) begin
                r_handle <= i_value;
            end else if (i_cmd.ins_new && w_victim) begin
                r_tag    <= i_key;
                r_handle <= i_value;
            end
        end
    end

endmodule

>>> src/lru_tag_cache_core.sv
// Fully associative tag cache with least-recently-used replacement.
// Request channel: i_opcode, i_key, i_value are taken at a rising edge where
// start is high and busy is low. Opcodes: lookup, insert, probe, clear.
// Result channel: o_valid is high for exactly one cycle with o_hit, o_data and
// o_entry_count; the receiver must take it then, it cannot hold results off.
// A request passes through the compare state and then the update state; the
// result strobe is registered from the update state.
// Requests overlap: busy is high for the one cycle in which the row of entry
// cells compares the key against every stored tag; in the following cycle the
// cells update rank, tag and handle while the next request may already be
// accepted.
// Free-slot choice ripples cell to cell (lowest free slot wins); on a full
// cache the least recent entry is overwritten.
// Reset (synchronous, active low) empties the cache: all entries invalid,
// count zero, no strobe pending. Tag and handle storage are not cleared.
module lru_tag_cache_core
    import lrutc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [DATA_W-1:0]   i_value,
    output logic                o_valid,
    output logic                o_hit,
    output logic [DATA_W-1:0]   o_data,
    output logic [COUNT_W-1:0]  o_entry_count
);

`include "lru_tag_cache_core_defines.svh"

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MATCH  = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0] r_phase;
    logic [1:0] n_phase;

    logic [OPCODE_W-1:0]   r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    logic                r_done;
    logic                r_hit;
    logic [DATA_W-1:0]   r_data;

    logic w_accept;
    logic w_hit;
    logic w_full;
    t_cell_cmd w_cmd;

    logic [ENTRIES-1:0]    w_match;
    logic [ENTRIES:0]      w_free_chain;
    logic [VALUE_BITS-1:0] w_cell_handle [ENTRIES];
    logic [RANK_W-1:0]     w_cell_rank   [ENTRIES];
    logic [VALUE_BITS-1:0] w_sel_handle;
    logic [RANK_W-1:0]     w_sel_rank;

    assign busy     = (r_phase == S_MATCH);
    assign w_accept = start && !busy;
    assign w_hit    = (r_op != OP_CLEAR) && (|w_match);
    assign w_full   = (r_count == CNT_W'(ENTRIES));

    always_comb begin
        unique case (r_phase)
            S_IDLE:   n_phase = w_accept ? S_MATCH : S_IDLE;
            S_MATCH:  n_phase = S_UPDATE;
            S_UPDATE: n_phase = w_accept ? S_MATCH : S_IDLE;
            default:  n_phase = S_IDLE;
        endcase
    end

    always_comb begin
        w_sel_handle = '0;
        w_sel_rank   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_sel_handle = w_sel_handle | w_cell_handle[i];
            w_sel_rank   = w_sel_rank | w_cell_rank[i];
        end
    end

    always_comb begin
        w_cmd.cmp       = (r_phase == S_MATCH);
        w_cmd.upd       = (r_phase == S_UPDATE);
        w_cmd.clr       = (r_op == OP_CLEAR);
        w_cmd.touch     = ((r_op == OP_LOOKUP) || (r_op == OP_INSERT)) && w_hit;
        w_cmd.ins_new   = (r_op == OP_INSERT) && !w_hit;
        w_cmd.wr_handle = (r_op == OP_INSERT);
        w_cmd.full      = w_full;
        w_cmd.hit_rank  = w_sel_rank;
    end

    always_comb begin
        n_count = r_count;
        if (r_phase == S_UPDATE) begin
            if (r_op == OP_CLEAR) begin
                n_count = '0;
            end else if (w_cmd.ins_new && !w_full) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    assign w_free_chain[0] = 1'b0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lrutc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_key        (r_key),
            .i_value      (r_value),
            .i_free_seen  (w_free_chain[g]),
            .o_free_seen  (w_free_chain[g+1]),
            .o_match      (w_match[g]),
            .o_hit_handle (w_cell_handle[g]),
            .o_hit_rank   (w_cell_rank[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_done  <= (r_phase == S_UPDATE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_opcode;
            r_key   <= KEY_BITS'(i_key);
            r_value <= VALUE_BITS'(i_value);
        end
        if (r_phase == S_UPDATE) begin
            r_hit  <= w_hit;
            r_data <= ((r_op == OP_LOOKUP) && w_hit) ? DATA_W'(w_sel_handle) : '0;
        end
    end

    assign o_valid       = r_done;
    assign o_hit         = r_hit;
    assign o_data        = r_data;
    assign o_entry_count = COUNT_W'(r_count);

    `LTC_ASSERT_NOW(a_match_onehot, i_clk, i_rst_n, r_phase == S_UPDATE,
        $onehot0(w_match), "more than one entry matched the key")
    `LTC_ASSERT_NOW(a_result_latency, i_clk, i_rst_n, w_accept,
        ##3 o_valid, "accepted request produced no result")
    `LTC_ASSERT_NEXT(a_busy_single, i_clk, i_rst_n, busy,
        !busy, "compare phase lasted more than one cycle")
    `LTC_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(ENTRIES), "entry count exceeds capacity")
    `LTC_ASSERT_NOW(a_free_slot, i_clk, i_rst_n,
        (r_phase == S_UPDATE) && w_cmd.ins_new && !w_full,
        w_free_chain[ENTRIES], "no free entry although the cache is not full")

endmodule
